// ----- design/tdp_pkg.sv -----
// ----------------------------------------------------------------------------
// tdp_pkg: shared types and constants for the trial division primality test
// Value width, step counter width and the divisor step.
// ----------------------------------------------------------------------------
package tdp_pkg;

  // width of the tested value
  localparam int VALUE_WIDTH = 30;

  // bit counter for one serial division pass
  localparam int CNT_W = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;

  typedef logic [VALUE_WIDTH-1:0] value_t;
  typedef logic [CNT_W-1:0]       cnt_t;

  // first odd trial divisor and the stride between divisors
  localparam value_t FIRST_DIVISOR = value_t'(3);
  localparam value_t DIVISOR_STEP  = value_t'(2);

endpackage

// ----- design/trial_division_primality.sv -----
// ----------------------------------------------------------------------------
// trial_division_primality: bit-serial trial division primality test
// Tests one unsigned value per item and returns one is_prime flag per item.
// ----------------------------------------------------------------------------
// One item is worked on at a time. Values 0, 1 and even values are settled at
// once and skip the division. An odd value is divided by the odd divisors 3,
// 5, 7 and so on with a restoring divider that produces one quotient bit per
// cycle, one full division pass per trial divisor. The search ends when a
// remainder is zero or the divisor exceeds the quotient. The result sits in an
// output register, so a new item is taken while the previous result still
// waits.
module trial_division_primality
  import tdp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  value_t     in_number,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_is_prime
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0] state_r, state_nxt;
  value_t     num_r, num_nxt;
  value_t     div_r, div_nxt;
  value_t     dvd_r, dvd_nxt;
  value_t     rem_r, rem_nxt;
  cnt_t       cnt_r, cnt_nxt;
  logic       res_r, res_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_prime_r, out_prime_nxt;

  logic                 in_acc;
  logic                 out_free;
  logic [VALUE_WIDTH:0] shifted;
  logic [VALUE_WIDTH:0] diff;
  logic                 qbit;
  value_t               step_rem;
  value_t               step_quo;

  assign in_stall     = (state_r != S_IDLE);
  assign in_acc       = in_valid && !in_stall;
  assign out_valid    = out_valid_r;
  assign out_is_prime = out_prime_r;
  assign out_free     = !out_valid_r || !out_stall;

  // one restoring division step: shift in a dividend bit, try the subtract
  always_comb begin
    shifted  = {rem_r, dvd_r[VALUE_WIDTH-1]};
    diff     = shifted - {1'b0, div_r};
    qbit     = !diff[VALUE_WIDTH];
    step_rem = qbit ? diff[VALUE_WIDTH-1:0] : shifted[VALUE_WIDTH-1:0];
    step_quo = {dvd_r[VALUE_WIDTH-2:0], qbit};
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    num_nxt       = num_r;
    div_nxt       = div_r;
    dvd_nxt       = dvd_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_prime_nxt = out_prime_r;

    // output register drains
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          num_nxt = in_number;
          div_nxt = FIRST_DIVISOR;
          dvd_nxt = in_number;
          rem_nxt = '0;
          cnt_nxt = cnt_t'(VALUE_WIDTH - 1);
          // zero, one, two and even values need no division
          if (in_number[VALUE_WIDTH-1:1] == '0) begin
            res_nxt   = 1'b0;
            state_nxt = S_FIN;
          end else if (in_number == value_t'(2)) begin
            res_nxt   = 1'b1;
            state_nxt = S_FIN;
          end else if (!in_number[0]) begin
            res_nxt   = 1'b0;
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        dvd_nxt = step_quo;
        rem_nxt = step_rem;
        cnt_nxt = cnt_r - cnt_t'(1);
        if (cnt_r == '0) begin
          // pass done: quotient and remainder are final
          if (div_r > step_quo) begin
            res_nxt   = 1'b1;
            state_nxt = S_FIN;
          end else if (step_rem == '0) begin
            res_nxt   = 1'b0;
            state_nxt = S_FIN;
          end else begin
            div_nxt = div_r + DIVISOR_STEP;
            dvd_nxt = num_r;
            rem_nxt = '0;
            cnt_nxt = cnt_t'(VALUE_WIDTH - 1);
          end
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_prime_nxt = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    num_r       <= num_nxt;
    div_r       <= div_nxt;
    dvd_r       <= dvd_nxt;
    rem_r       <= rem_nxt;
    cnt_r       <= cnt_nxt;
    res_r       <= res_nxt;
    out_prime_r <= out_prime_nxt;
  end

endmodule
